/* src/ieas_pkg.sv */
package ieas_pkg;

    // Default sizes handed to the top level parameters.
    localparam int ADDR_BITS_DEF  = 16;
    localparam int ACT_DEPTH_DEF  = 4;

    // Register reset values.
    localparam logic [15:0] MAX_ADDR_RST  = 16'd255;
    localparam logic        TWO_BYTE_RST  = 1'b0;
    localparam logic [7:0]  WR_CTRL_RST   = 8'd160;
    localparam logic [7:0]  RD_CTRL_RST   = 8'd161;
    localparam logic [7:0]  WR_DELAY_RST  = 8'd5;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MAX_ADDR = 3'd0,
        CFG_TWO_BYTE = 3'd1,
        CFG_WR_CTRL  = 3'd2,
        CFG_RD_CTRL  = 3'd3,
        CFG_WR_DELAY = 3'd4
    } t_cfg_index;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_RBYTE = 2'd3
    } t_kind;

    // Bus primitives issued to the bus engine.
    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_SEND     = 3'd1,
        CMD_WAIT_ACK = 3'd2,
        CMD_RECV     = 3'd3,
        CMD_NACK     = 3'd4,
        CMD_STOP     = 3'd5,
        CMD_DELAY    = 3'd6,
        CMD_DONE     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NO_ACK = 2'd2
    } t_status;

    // Transaction phase of the front end.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ACK_CTRL  = 3'd1,
        PH_ACK_HIGH  = 3'd2,
        PH_ACK_LOW   = 3'd3,
        PH_ACK_DATA  = 3'd4,
        PH_ACK_RDCTL = 3'd5,
        PH_RECV      = 3'd6
    } t_phase;

    // Actions queued from the front end to the back end. Each one expands
    // into a fixed run of bus primitives.
    typedef enum logic [2:0] {
        ACT_RANGE      = 3'd0,
        ACT_START_SEND = 3'd1,
        ACT_SEND       = 3'd2,
        ACT_FAIL       = 3'd3,
        ACT_WRITE_END  = 3'd4,
        ACT_RECV       = 3'd5,
        ACT_READ_END   = 3'd6
    } t_act;

    typedef struct packed {
        t_act       code;
        logic [7:0] byte_value;
    } t_action;

    typedef struct packed {
        logic [15:0] max_address;
        logic        two_byte_addressing;
        logic [7:0]  write_control_byte;
        logic [7:0]  read_control_byte;
        logic [7:0]  write_delay_ms;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        ack_ok;
        logic [7:0]  received_byte;
    } t_in_item;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] byte_value;
        t_status    status;
        logic [7:0] read_data;
        logic       last;
    } t_out_item;

endpackage

/* src/ieas_front.sv */
module ieas_front #(
    parameter int ADDRESS_BITS = ieas_pkg::ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ieas_pkg::t_in_item i_item,
    input  ieas_pkg::t_cfg    i_cfg,
    output logic              o_act_valid,
    output ieas_pkg::t_action o_act
);
    import ieas_pkg::*;

    t_phase                    r_phase, n_phase;
    logic                      r_is_write, n_is_write;
    logic [ADDRESS_BITS-1:0]   r_held_address, n_held_address;
    logic [7:0]                r_held_data, n_held_data;

    logic [15:0] in_addr;
    logic [15:0] held_addr;

    // Request address limited to the device address width.
    assign in_addr   = 16'(i_item.address[ADDRESS_BITS-1:0]);
    assign held_addr = 16'(r_held_address);

    // Phase register and held request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_is_write     <= 1'b0;
            r_held_address <= '0;
            r_held_data    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_is_write     <= n_is_write;
            r_held_address <= n_held_address;
            r_held_data    <= n_held_data;
        end
    end

    // Classify each transfer into an action and advance the phase.
    always_comb begin
        n_phase           = r_phase;
        n_is_write        = r_is_write;
        n_held_address    = r_held_address;
        n_held_data       = r_held_data;
        o_act_valid       = 1'b0;
        o_act.code        = ACT_RANGE;
        o_act.byte_value  = '0;
        if (i_valid) begin
            case (i_item.kind)
                KIND_READ, KIND_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        o_act_valid = 1'b1;
                        if (in_addr > i_cfg.max_address) begin
                            o_act.code = ACT_RANGE;
                        end else begin
                            n_is_write     = (i_item.kind == KIND_WRITE);
                            n_held_address = in_addr[ADDRESS_BITS-1:0];
                            n_held_data    = i_item.write_data;
                            n_phase        = PH_ACK_CTRL;
                            o_act.code     = ACT_START_SEND;
                            if (i_cfg.two_byte_addressing) begin
                                o_act.byte_value = i_cfg.write_control_byte;
                            end else begin
                                // Block bits go into the control byte.
                                o_act.byte_value = i_cfg.write_control_byte
                                                   + {in_addr[14:8], 1'b0};
                            end
                        end
                    end
                end
                KIND_ACK: begin
                    if (r_phase inside {PH_ACK_CTRL, PH_ACK_HIGH, PH_ACK_LOW,
                                        PH_ACK_DATA, PH_ACK_RDCTL}) begin
                        o_act_valid = 1'b1;
                        if (!i_item.ack_ok) begin
                            o_act.code = ACT_FAIL;
                            n_phase    = PH_IDLE;
                        end else begin
                            case (r_phase)
                                PH_ACK_CTRL: begin
                                    o_act.code = ACT_SEND;
                                    if (i_cfg.two_byte_addressing) begin
                                        o_act.byte_value = held_addr[15:8];
                                        n_phase          = PH_ACK_HIGH;
                                    end else begin
                                        o_act.byte_value = held_addr[7:0];
                                        n_phase          = PH_ACK_LOW;
                                    end
                                end
                                PH_ACK_HIGH: begin
                                    o_act.code       = ACT_SEND;
                                    o_act.byte_value = held_addr[7:0];
                                    n_phase          = PH_ACK_LOW;
                                end
                                PH_ACK_LOW: begin
                                    if (r_is_write) begin
                                        o_act.code       = ACT_SEND;
                                        o_act.byte_value = r_held_data;
                                        n_phase          = PH_ACK_DATA;
                                    end else begin
                                        // Repeated start with the read control byte.
                                        o_act.code       = ACT_START_SEND;
                                        o_act.byte_value = i_cfg.read_control_byte;
                                        n_phase          = PH_ACK_RDCTL;
                                    end
                                end
                                PH_ACK_DATA: begin
                                    o_act.code       = ACT_WRITE_END;
                                    o_act.byte_value = i_cfg.write_delay_ms;
                                    n_phase          = PH_IDLE;
                                end
                                default: begin
                                    o_act.code = ACT_RECV;
                                    n_phase    = PH_RECV;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    if (r_phase == PH_RECV) begin
                        o_act_valid      = 1'b1;
                        o_act.code       = ACT_READ_END;
                        o_act.byte_value = i_item.received_byte;
                        n_phase          = PH_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* src/ieas_fifo.sv */
module ieas_fifo #(
    parameter int DEPTH = ieas_pkg::ACT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ieas_pkg::t_action i_data,
    input  logic              i_pop,
    output ieas_pkg::t_action o_data,
    output logic              o_full,
    output logic              o_empty
);
    import ieas_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_action           r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/ieas_back.sv */
module ieas_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ieas_pkg::t_action   i_act,
    input  logic                i_act_empty,
    output logic                o_act_pop,
    output ieas_pkg::t_out_item o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import ieas_pkg::*;

    logic [1:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  step_item;
    logic       advance;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign advance  = (!r_out_valid || i_pop) && !i_act_empty;
    assign o_act_pop = advance && step_item.last;

    // Expand the head action into its run of bus primitives.
    always_comb begin
        step_item.command    = CMD_DONE;
        step_item.byte_value = '0;
        step_item.status     = ST_OK;
        step_item.read_data  = '0;
        step_item.last       = 1'b1;
        case (i_act.code)
            ACT_RANGE: begin
                step_item.status = ST_RANGE;
            end
            ACT_START_SEND: begin
                case (r_step)
                    2'd0: begin
                        step_item.command = CMD_START;
                        step_item.last    = 1'b0;
                    end
                    2'd1: begin
                        step_item.command    = CMD_SEND;
                        step_item.byte_value = i_act.byte_value;
                        step_item.last       = 1'b0;
                    end
                    default: step_item.command = CMD_WAIT_ACK;
                endcase
            end
            ACT_SEND: begin
                case (r_step)
                    2'd0: begin
                        step_item.command    = CMD_SEND;
                        step_item.byte_value = i_act.byte_value;
                        step_item.last       = 1'b0;
                    end
                    default: step_item.command = CMD_WAIT_ACK;
                endcase
            end
            ACT_FAIL: begin
                case (r_step)
                    2'd0: begin
                        step_item.command = CMD_STOP;
                        step_item.last    = 1'b0;
                    end
                    default: step_item.status = ST_NO_ACK;
                endcase
            end
            ACT_WRITE_END: begin
                case (r_step)
                    2'd0: begin
                        step_item.command = CMD_STOP;
                        step_item.last    = 1'b0;
                    end
                    2'd1: begin
                        step_item.command    = CMD_DELAY;
                        step_item.byte_value = i_act.byte_value;
                        step_item.last       = 1'b0;
                    end
                    default: step_item.command = CMD_DONE;
                endcase
            end
            ACT_RECV: begin
                step_item.command = CMD_RECV;
            end
            ACT_READ_END: begin
                case (r_step)
                    2'd0: begin
                        step_item.command = CMD_NACK;
                        step_item.last    = 1'b0;
                    end
                    2'd1: begin
                        step_item.command = CMD_STOP;
                        step_item.last    = 1'b0;
                    end
                    default: step_item.read_data = i_act.byte_value;
                endcase
            end
            default: begin
                step_item.command = CMD_DONE;
            end
        endcase
    end

    // Output register and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step      <= step_item.last ? 2'd0 : r_step + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_item;
        end
    end

endmodule

/* src/i2c_eeprom_access_sequencer.sv */
// Master-side sequencer for single-byte EEPROM random reads and byte writes.
// Requests, acknowledge reports and received bytes enter through push/full
// and the resulting bus primitives leave through empty/pop, each run closed
// by a result with last set. An input transfer is taken every cycle while
// the action queue (FIFO_DEPTH entries) has room; the front end turns each
// item combinationally into an action, and the back end emits one primitive
// per cycle while its output is empty or popped, so an item yields 0 to 3
// results and the output side sets the sustained rate. Items that arrive
// in the wrong phase are dropped without a result. Configuration writes are
// taken at any cycle and must be made only while the block is idle.
module i2c_eeprom_access_sequencer #(
    parameter int ADDRESS_BITS = ieas_pkg::ADDR_BITS_DEF,
    parameter int FIFO_DEPTH   = ieas_pkg::ACT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ieas_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output ieas_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import ieas_pkg::*;

    t_cfg    r_cfg;
    t_action act, head;
    logic    act_valid, act_full, act_empty, act_pop;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_address         <= MAX_ADDR_RST;
            r_cfg.two_byte_addressing <= TWO_BYTE_RST;
            r_cfg.write_control_byte  <= WR_CTRL_RST;
            r_cfg.read_control_byte   <= RD_CTRL_RST;
            r_cfg.write_delay_ms      <= WR_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ADDR: r_cfg.max_address         <= i_cfg_data;
                CFG_TWO_BYTE: r_cfg.two_byte_addressing <= i_cfg_data[0];
                CFG_WR_CTRL:  r_cfg.write_control_byte  <= i_cfg_data[7:0];
                CFG_RD_CTRL:  r_cfg.read_control_byte   <= i_cfg_data[7:0];
                CFG_WR_DELAY: r_cfg.write_delay_ms      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign full = act_full;

    ieas_front #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push && !act_full),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_act_valid(act_valid),
        .o_act      (act)
    );

    ieas_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (act_valid),
        .i_data (act),
        .i_pop  (act_pop),
        .o_data (head),
        .o_full (act_full),
        .o_empty(act_empty)
    );

    ieas_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act      (head),
        .i_act_empty(act_empty),
        .o_act_pop  (act_pop),
        .o_result   (o_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule
